// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with synchronous rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ps2dlt_pkg.sv
// ----------------------------------------------------------------------------
// ps2dlt_pkg
// types and constants of the ps/2 device-side link transceiver
// ----------------------------------------------------------------------------
package ps2dlt_pkg;

  localparam int CFG_W       = 16;
  localparam int TIMER_BITS_DEF = 16;
  localparam int IN_W        = 16;
  localparam int OUT_W       = 16;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [CFG_W-1:0] RST_HALF     = 16'd20;
  localparam logic [CFG_W-1:0] RST_FULL     = 16'd40;
  localparam logic [CFG_W-1:0] RST_BYTEWAIT = 16'd50;
  localparam logic [CFG_W-1:0] RST_CLKWAIT  = 16'd750;

  localparam logic [CFG_ADDR_W-1:0] REG_HALF     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BYTEWAIT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CLKWAIT  = 2'd3;

  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_POLL = 2'd2;

  localparam logic [3:0] STS_NONE   = 4'd0;
  localparam logic [3:0] STS_SENT   = 4'd1;
  localparam logic [3:0] STS_INHIB  = 4'd2;
  localparam logic [3:0] STS_HREQ   = 4'd3;
  localparam logic [3:0] STS_INTR   = 4'd4;
  localparam logic [3:0] STS_NOREQ  = 4'd5;
  localparam logic [3:0] STS_RECV   = 4'd6;
  localparam logic [3:0] STS_PERR   = 4'd7;
  localparam logic [3:0] STS_FRAME  = 4'd8;

  localparam logic [3:0] BIT_PARITY = 4'd9;
  localparam logic [3:0] BIT_STOP   = 4'd10;
  localparam logic [3:0] BIT_DATA8  = 4'd8;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_TX_PRE1  = 16'h0002,
    ST_TX_PRE2  = 16'h0004,
    ST_TX_SETUP = 16'h0008,
    ST_TX_LOW   = 16'h0010,
    ST_TX_HIGH  = 16'h0020,
    ST_PL_SETTLE= 16'h0040,
    ST_RD_SETTLE= 16'h0080,
    ST_RD_REL   = 16'h0100,
    ST_RD_FALL  = 16'h0200,
    ST_RD_GO    = 16'h0400,
    ST_RD_LOW   = 16'h0800,
    ST_RD_HIGH  = 16'h1000,
    ST_ST_LOW   = 16'h2000,
    ST_ST_HIGH  = 16'h4000,
    ST_ACK      = 16'h8000
  } state_t;

endpackage

// File: src/ps2_device_link_transceiver_top.sv
// the result of an accepted request is written to the output register at the accepting clock edge
// throughput: one request per cycle while out_tready is high, set by the single-pass state update logic
// the output register frees in the cycle its result is taken, so no bubble
// reset: synchronous active-low rst_n clears control state and the output valid
// and loads the phase registers with 20, 40, 50 and 750 ticks
// ----------------------------------------------------------------------------
// ps2_device_link_transceiver_top
// device side of a ps/2 link, one request per microsecond tick
// ----------------------------------------------------------------------------
module ps2_device_link_transceiver_top
  import ps2dlt_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // action[1:0] tx_byte[9:2] clk_level[10] dat_level[11]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // drive_clk_low[0] drive_dat_low[1] busy_res[2]
                                            // status[6:3] rx_byte[14:7]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

`include "assert_macros.svh"

  localparam int CMP_W = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
  localparam logic [CMP_W-1:0] TMAX = CMP_W'((64'(1) << TIMER_BITS) - 64'(1));

  logic [CFG_W-1:0] half_r, full_r, bwait_r, cwait_r;

  state_t                state_r, state_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [3:0]            bitcnt_r, bitcnt_nxt;
  logic [7:0]            shreg_r, shreg_nxt;
  logic                  par_r, par_nxt;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic       accept;
  logic [1:0] act;
  logic [7:0] txb;
  logic       lclk, ldat;
  logic [3:0] sts;
  logic [7:0] rx;
  logic       dclk, ddat, txbit;
  logic [CMP_W-1:0] t_ext, t_inc;

  function automatic logic [CMP_W-1:0] clamp(input logic [CFG_W-1:0] lim);
    logic [CMP_W-1:0] e;
    e = CMP_W'(lim);
    return (e > TMAX) ? TMAX : e;
  endfunction

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign act   = in_tdata[1:0];
  assign txb   = in_tdata[9:2];
  assign lclk  = in_tdata[10];
  assign ldat  = in_tdata[11];
  assign t_ext = CMP_W'(timer_r);
  assign t_inc = t_ext + CMP_W'(1);

  always_comb begin
    logic [CFG_W-1:0] lim;
    logic             hit;
    state_nxt  = state_r;
    timer_nxt  = timer_r;
    bitcnt_nxt = bitcnt_r;
    shreg_nxt  = shreg_r;
    par_nxt    = par_r;
    sts        = STS_NONE;
    rx         = 8'd0;
    lim        = full_r;
    unique case (state_r)
      ST_TX_PRE1, ST_TX_SETUP, ST_TX_HIGH, ST_RD_REL: lim = half_r;
      ST_TX_PRE2: lim = bwait_r;
      default:    lim = full_r;
    endcase
    hit = (t_inc >= clamp(lim));
    if (state_r != ST_IDLE && state_r != ST_RD_FALL) begin
      timer_nxt = hit ? '0 : timer_r + TIMER_BITS'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (act == ACT_SEND) begin
          shreg_nxt = txb;
          par_nxt = 1'b1;
          bitcnt_nxt = 4'd0;
          state_nxt = ST_TX_PRE1;
          timer_nxt = '0;
        end else if (act == ACT_POLL) begin
          shreg_nxt = 8'd0;
          par_nxt = 1'b1;
          bitcnt_nxt = 4'd0;
          state_nxt = ST_PL_SETTLE;
          timer_nxt = '0;
        end
      end
      ST_TX_PRE1, ST_TX_PRE2: begin
        if (hit) begin
          if (!lclk) begin
            sts = STS_INHIB;
            state_nxt = ST_IDLE;
          end else if (!ldat) begin
            sts = STS_HREQ;
            state_nxt = ST_IDLE;
          end else if (state_r == ST_TX_PRE1) begin
            state_nxt = ST_TX_PRE2;
          end else begin
            bitcnt_nxt = 4'd0;
            state_nxt = ST_TX_SETUP;
          end
        end
      end
      ST_TX_SETUP: if (hit) state_nxt = ST_TX_LOW;
      ST_TX_LOW:   if (hit) state_nxt = ST_TX_HIGH;
      ST_TX_HIGH: begin
        if (hit) begin
          if (!lclk && bitcnt_r < BIT_STOP) begin
            sts = (bitcnt_r == 4'd0) ? STS_INHIB : STS_INTR;
            state_nxt = ST_IDLE;
          end else if (bitcnt_r >= BIT_STOP) begin
            sts = STS_SENT;
            state_nxt = ST_IDLE;
          end else begin
            if (bitcnt_r >= 4'd1 && bitcnt_r <= BIT_DATA8) begin
              par_nxt = par_r ^ shreg_r[0];
              shreg_nxt = {1'b0, shreg_r[7:1]};
            end
            bitcnt_nxt = bitcnt_r + 4'd1;
            state_nxt = ST_TX_SETUP;
          end
        end
      end
      ST_PL_SETTLE: begin
        if (hit) begin
          if (ldat && lclk) begin
            sts = STS_NOREQ;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD_SETTLE;
          end
        end
      end
      ST_RD_SETTLE: if (hit) state_nxt = lclk ? ST_RD_FALL : ST_RD_REL;
      ST_RD_REL: begin
        if (hit && lclk) begin
          if (ldat) begin
            sts = STS_FRAME;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD_GO;
          end
        end
      end
      ST_RD_FALL: begin
        if (!lclk || t_ext >= clamp(cwait_r)) begin
          timer_nxt = '0;
          if (ldat) begin
            sts = STS_FRAME;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD_GO;
          end
        end else begin
          timer_nxt = timer_r + TIMER_BITS'(1);
        end
      end
      ST_RD_GO: begin
        if (hit) begin
          bitcnt_nxt = 4'd0;
          state_nxt = ST_RD_LOW;
        end
      end
      ST_RD_LOW: if (hit) state_nxt = ST_RD_HIGH;
      ST_RD_HIGH: begin
        if (hit) begin
          par_nxt = par_r ^ ldat;
          if (bitcnt_r < BIT_DATA8) begin
            shreg_nxt = {ldat, shreg_r[7:1]};
            bitcnt_nxt = bitcnt_r + 4'd1;
            state_nxt = ST_RD_LOW;
          end else begin
            state_nxt = ST_ST_LOW;
          end
        end
      end
      ST_ST_LOW:  if (hit) state_nxt = ST_ST_HIGH;
      ST_ST_HIGH: if (hit) state_nxt = ST_ACK;
      ST_ACK: begin
        if (hit) begin
          sts = par_r ? STS_PERR : STS_RECV;
          rx = shreg_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  always_comb begin
    if (bitcnt_nxt == 4'd0) begin
      txbit = 1'b0;
    end else if (bitcnt_nxt <= BIT_DATA8) begin
      txbit = shreg_nxt[0];
    end else if (bitcnt_nxt == BIT_PARITY) begin
      txbit = par_nxt;
    end else begin
      txbit = 1'b1;
    end
    dclk = 1'b0;
    ddat = 1'b0;
    unique case (state_nxt)
      ST_TX_SETUP, ST_TX_HIGH: ddat = !txbit;
      ST_TX_LOW: begin
        ddat = !txbit;
        dclk = 1'b1;
      end
      ST_RD_LOW, ST_ST_LOW: dclk = 1'b1;
      ST_ACK: begin
        dclk = 1'b1;
        ddat = 1'b1;
      end
      default: ;
    endcase
    out_data_nxt = {1'b0, rx, sts, (state_nxt != ST_IDLE), ddat, dclk};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= RST_HALF;
      full_r  <= RST_FULL;
      bwait_r <= RST_BYTEWAIT;
      cwait_r <= RST_CLKWAIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HALF:     half_r  <= cfg_wdata;
        REG_FULL:     full_r  <= cfg_wdata;
        REG_BYTEWAIT: bwait_r <= cfg_wdata;
        REG_CLKWAIT:  cwait_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timer_r     <= '0;
      bitcnt_r    <= 4'd0;
      shreg_r     <= 8'd0;
      par_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r  <= state_nxt;
        timer_r  <= timer_nxt;
        bitcnt_r <= bitcnt_nxt;
        shreg_r  <= shreg_nxt;
        par_r    <= par_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_SAME(a_status_ends_op, out_valid_r && (out_data_r[6:3] != STS_NONE), !out_data_r[2])
  `ASSERT_SAME(a_clk_drive_busy, out_valid_r && out_data_r[0], out_data_r[2])
  `ASSERT_SAME(a_bitcnt_range, 1'b1, bitcnt_r <= BIT_STOP)
  `ASSERT_NEXT(a_poll_starts, accept && (state_r == ST_IDLE) && (act == ACT_POLL),
               out_valid_r && out_data_r[2] && (state_r == ST_PL_SETTLE))

endmodule
